// ----- rtl/itf_pkg.sv -----
`timescale 1ns / 1ps

package itf_pkg;

  // line shape limits
  localparam int unsigned MaxWidth   = 255;
  localparam int unsigned ChunkBytes = 8;

  // decimal conversion chain
  localparam int unsigned BcdDigits = 20;
  localparam int unsigned DigW      = 4 * BcdDigits;

  // configuration register indexes
  localparam logic [2:0] REG_TYPE  = 3'd0;
  localparam logic [2:0] REG_FILL  = 3'd1;
  localparam logic [2:0] REG_ALIGN = 3'd2;
  localparam logic [2:0] REG_SIGN  = 3'd3;
  localparam logic [2:0] REG_ALT   = 3'd4;
  localparam logic [2:0] REG_ZPAD  = 3'd5;
  localparam logic [2:0] REG_WIDTH = 3'd6;

  // presentation types
  localparam logic [2:0] TYPE_DEC    = 3'd0;
  localparam logic [2:0] TYPE_BIN_L  = 3'd1;
  localparam logic [2:0] TYPE_BIN_U  = 3'd2;
  localparam logic [2:0] TYPE_OCT    = 3'd3;
  localparam logic [2:0] TYPE_HEX_L  = 3'd4;
  localparam logic [2:0] TYPE_HEX_U  = 3'd5;
  localparam logic [2:0] TYPE_CHAR   = 3'd6;
  localparam logic [2:0] TYPE_UNUSED = 3'd7;

  // alignment and sign modes
  localparam logic [1:0] ALIGN_DEF    = 2'd0;
  localparam logic [1:0] ALIGN_LEFT   = 2'd1;
  localparam logic [1:0] ALIGN_RIGHT  = 2'd2;
  localparam logic [1:0] ALIGN_CENTER = 2'd3;
  localparam logic [1:0] SIGN_MINUS   = 2'd0;
  localparam logic [1:0] SIGN_PLUS    = 2'd1;
  localparam logic [1:0] SIGN_SPACE   = 2'd2;
  localparam logic [1:0] SIGN_UNUSED  = 2'd3;

  typedef enum logic [1:0] {
    BASE_DEC,
    BASE_BIN,
    BASE_OCT,
    BASE_HEX
  } base_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CONV,
    S_NORM,
    S_SETUP,
    S_LEAD,
    S_HEAD,
    S_ZERO,
    S_DIGIT,
    S_TRAIL
  } state_e;

  // ascii for one digit value
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = 8'h30 + {4'd0, d};
    end else if (upper) begin
      r = 8'h41 + {4'd0, d} - 8'd10;
    end else begin
      r = 8'h61 + {4'd0, d} - 8'd10;
    end
    return r;
  endfunction

endpackage

// ----- rtl/itf_bcd_cell.sv -----
`timescale 1ns / 1ps

module itf_bcd_cell (
  input  logic       clk_i,
  input  logic       clr_i,
  input  logic       en_i,
  input  logic       bit_i,
  output logic       bit_o,
  output logic [3:0] digit_o
);

  logic [3:0] dig_q, dig_d, adj;

  // add three when the digit would overflow after the shift
  always_comb begin
    adj   = (dig_q >= 4'd5) ? dig_q + 4'd3 : dig_q;
    bit_o = adj[3];
    dig_d = dig_q;
    if (clr_i) begin
      dig_d = 4'd0;
    end else if (en_i) begin
      dig_d = {adj[2:0], bit_i};
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
  end

  assign digit_o = dig_q;

endmodule

// ----- rtl/itf_digit_chain.sv -----
`timescale 1ns / 1ps

module itf_digit_chain (
  input  logic                       clk_i,
  input  logic                       clr_i,
  input  logic                       en_i,
  input  logic                       bit_i,
  output logic [itf_pkg::DigW-1:0]   bcd_o
);

  logic [itf_pkg::BcdDigits:0] carry;

  assign carry[0] = bit_i;

  // one cell per decimal digit, the adjusted top bit of each cell feeds the next cell up
  for (genvar k = 0; k < itf_pkg::BcdDigits; k++) begin : g_cell
    itf_bcd_cell u_cell (
      .clk_i  (clk_i),
      .clr_i  (clr_i),
      .en_i   (en_i),
      .bit_i  (carry[k]),
      .bit_o  (carry[k+1]),
      .digit_o(bcd_o[4*k +: 4])
    );
  end

endmodule

// ----- rtl/integer_text_formatter_core.sv -----
`timescale 1ns / 1ps
// sequence: decimal values shift through the bcd chain, then drop leading zero digits;
// other bases only drop leading zero digits; then setup and the segments emit the bytes.
// a chunk strobe comes in the cycle after each ChunkBytes-th byte and after the final byte.
// throughput: one value at a time; busy holds off the next start until the last byte.
// char range error: one strobe the cycle after start, busy stays low.
// reset clears the format registers (fill byte to space) and the sequencer; no stall.

module integer_text_formatter_core #(
  parameter int unsigned MaxWidth   = itf_pkg::MaxWidth,
  parameter int unsigned ChunkBytes = itf_pkg::ChunkBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic [63:0] value_i,
  input  logic        is_signed_i,
  output logic        valid_o,
  output logic [63:0] chunk_bytes_o,
  output logic [3:0]  byte_count_o,
  output logic        last_chunk_o,
  output logic        char_error_o
);

  localparam int unsigned DW = itf_pkg::DigW;

  // configuration registers
  logic [2:0] type_q;
  logic [7:0] fill_q;
  logic [1:0] align_q;
  logic [1:0] sign_q;
  logic       alt_q;
  logic       zpad_q;
  logic [7:0] fw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q  <= itf_pkg::TYPE_DEC;
      fill_q  <= 8'd32;
      align_q <= itf_pkg::ALIGN_DEF;
      sign_q  <= itf_pkg::SIGN_MINUS;
      alt_q   <= 1'b0;
      zpad_q  <= 1'b0;
      fw_q    <= 8'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        itf_pkg::REG_TYPE:  type_q  <= cfg_data_i[2:0];
        itf_pkg::REG_FILL:  fill_q  <= cfg_data_i;
        itf_pkg::REG_ALIGN: align_q <= cfg_data_i[1:0];
        itf_pkg::REG_SIGN:  sign_q  <= cfg_data_i[1:0];
        itf_pkg::REG_ALT:   alt_q   <= cfg_data_i[0];
        itf_pkg::REG_ZPAD:  zpad_q  <= cfg_data_i[0];
        itf_pkg::REG_WIDTH: fw_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer state
  itf_pkg::state_e state_q, state_d;
  itf_pkg::base_e  base_q, base_d;
  logic            upper_q, upper_d;
  logic            is_char_q, is_char_d;
  logic [63:0]     src_q, src_d;
  logic [DW-1:0]   dig_q, dig_d;
  logic [6:0]      nd_q, nd_d;
  logic [6:0]      cnt_q, cnt_d;
  logic [23:0]     head_q, head_d;
  logic [1:0]      hlen_q, hlen_d;
  logic [8:0]      seg_q, seg_d;
  logic [8:0]      zeros_q, zeros_d;
  logic [8:0]      trail_q, trail_d;
  logic [9:0]      rem_q, rem_d;
  logic [63:0]     acc_q, acc_d;
  logic [2:0]      n_q, n_d;
  logic            ov_q, ov_d;
  logic [63:0]     oc_q, oc_d;
  logic [3:0]      ob_q, ob_d;
  logic            ol_q, ol_d;
  logic            oe_q, oe_d;

  // decimal conversion chain
  logic            chain_clr, chain_en;
  logic [DW-1:0]   bcd;

  itf_digit_chain u_chain (
    .clk_i(clk_i),
    .clr_i(chain_clr),
    .en_i (chain_en),
    .bit_i(src_q[63]),
    .bcd_o(bcd)
  );

  // input decode
  logic        neg;
  logic [63:0] mag;
  logic        chr_bad;
  logic [7:0]  w;

  assign neg = is_signed_i & value_i[63];
  assign mag = neg ? (64'd0 - value_i) : value_i;
  assign chr_bad = neg ? (mag > 64'd128) : (mag > 64'd127);
  assign w = (32'(fw_q) > MaxWidth) ? 8'(MaxWidth) : fw_q;

  // top digit of the normalized digit register
  logic [3:0] top;
  logic [2:0] dw;

  always_comb begin
    case (base_q)
      itf_pkg::BASE_BIN: begin
        top = {3'd0, dig_q[DW-1]};
        dw  = 3'd1;
      end
      itf_pkg::BASE_OCT: begin
        top = {1'b0, dig_q[DW-1 -: 3]};
        dw  = 3'd3;
      end
      default: begin
        top = dig_q[DW-1 -: 4];
        dw  = 3'd4;
      end
    endcase
  end

  // body layout terms
  logic [6:0] blen;
  logic [8:0] slack;

  assign blen  = {5'd0, hlen_q} + nd_q;
  assign slack = ({1'b0, w} > {2'b0, blen}) ? ({1'b0, w} - {2'b0, blen}) : 9'd0;

  // byte transfer into the chunk assembler
  logic        emit;
  logic [7:0]  ebyte;
  logic [63:0] acc_new;

  always_comb begin
    logic [23:0] hd;
    logic [1:0]  hl;
    logic [8:0]  ld;
    logic [1:0]  am;

    state_d   = state_q;
    base_d    = base_q;
    upper_d   = upper_q;
    is_char_d = is_char_q;
    src_d     = src_q;
    dig_d     = dig_q;
    nd_d      = nd_q;
    cnt_d     = cnt_q;
    head_d    = head_q;
    hlen_d    = hlen_q;
    seg_d     = seg_q;
    zeros_d   = zeros_q;
    trail_d   = trail_q;
    rem_d     = rem_q;
    acc_d     = acc_q;
    n_d       = n_q;
    ov_d      = 1'b0;
    oc_d      = oc_q;
    ob_d      = ob_q;
    ol_d      = ol_q;
    oe_d      = oe_q;
    chain_clr = 1'b0;
    chain_en  = 1'b0;
    emit      = 1'b0;
    ebyte     = 8'd0;
    hd        = 24'd0;
    hl        = 2'd0;
    ld        = 9'd0;
    am        = 2'd0;

    case (state_q)
      itf_pkg::S_IDLE: begin
        if (start) begin
          upper_d = (type_q == itf_pkg::TYPE_BIN_U) || (type_q == itf_pkg::TYPE_HEX_U);
          if (type_q == itf_pkg::TYPE_CHAR) begin
            is_char_d = 1'b1;
            if (chr_bad) begin
              ov_d = 1'b1;
              oc_d = 64'd0;
              ob_d = 4'd0;
              ol_d = 1'b1;
              oe_d = 1'b1;
            end else begin
              head_d  = {16'd0, value_i[7:0]};
              hlen_d  = 2'd1;
              nd_d    = 7'd0;
              state_d = itf_pkg::S_SETUP;
            end
          end else begin
            is_char_d = 1'b0;
            // sign byte then prefix, packed first byte lowest
            if (neg) begin
              hd = {16'd0, 8'h2d};
              hl = 2'd1;
            end else if (sign_q == itf_pkg::SIGN_PLUS) begin
              hd = {16'd0, 8'h2b};
              hl = 2'd1;
            end else if (sign_q == itf_pkg::SIGN_SPACE) begin
              hd = {16'd0, 8'h20};
              hl = 2'd1;
            end
            case (type_q)
              itf_pkg::TYPE_BIN_L, itf_pkg::TYPE_BIN_U: begin
                base_d = itf_pkg::BASE_BIN;
                dig_d  = {mag, 16'd0};
                nd_d   = 7'd64;
                if (alt_q) begin
                  hd[8*hl +: 16] = {(type_q == itf_pkg::TYPE_BIN_U) ? 8'h42 : 8'h62, 8'h30};
                  hl = hl + 2'd2;
                end
              end
              itf_pkg::TYPE_OCT: begin
                base_d = itf_pkg::BASE_OCT;
                dig_d  = {2'd0, mag, 14'd0};
                nd_d   = 7'd22;
                if (alt_q && (mag != 64'd0)) begin
                  hd[8*hl +: 8] = 8'h30;
                  hl = hl + 2'd1;
                end
              end
              itf_pkg::TYPE_HEX_L, itf_pkg::TYPE_HEX_U: begin
                base_d = itf_pkg::BASE_HEX;
                dig_d  = {mag, 16'd0};
                nd_d   = 7'd16;
                if (alt_q) begin
                  hd[8*hl +: 16] = {(type_q == itf_pkg::TYPE_HEX_U) ? 8'h58 : 8'h78, 8'h30};
                  hl = hl + 2'd2;
                end
              end
              default: begin
                base_d = itf_pkg::BASE_DEC;
                nd_d   = 7'(itf_pkg::BcdDigits);
              end
            endcase
            head_d = hd;
            hlen_d = hl;
            if (base_d == itf_pkg::BASE_DEC) begin
              chain_clr = 1'b1;
              src_d     = mag;
              cnt_d     = 7'd64;
              state_d   = itf_pkg::S_CONV;
            end else begin
              state_d = itf_pkg::S_NORM;
            end
          end
        end
      end

      // shift one magnitude bit into the bcd chain per cycle
      itf_pkg::S_CONV: begin
        if (cnt_q == 7'd0) begin
          dig_d   = bcd;
          state_d = itf_pkg::S_NORM;
        end else begin
          chain_en = 1'b1;
          src_d    = {src_q[62:0], 1'b0};
          cnt_d    = cnt_q - 7'd1;
        end
      end

      // drop leading zero digits, keeping at least one
      itf_pkg::S_NORM: begin
        if ((top == 4'd0) && (nd_q > 7'd1)) begin
          dig_d = dig_q << dw;
          nd_d  = nd_q - 7'd1;
        end else begin
          state_d = itf_pkg::S_SETUP;
        end
      end

      // split the padding into lead, zero and trail runs
      itf_pkg::S_SETUP: begin
        zeros_d = 9'd0;
        if (!is_char_q && zpad_q && (align_q == itf_pkg::ALIGN_DEF)) begin
          zeros_d = slack;
          ld      = 9'd0;
          trail_d = 9'd0;
        end else begin
          am = align_q;
          if (align_q == itf_pkg::ALIGN_DEF) begin
            am = is_char_q ? itf_pkg::ALIGN_LEFT : itf_pkg::ALIGN_RIGHT;
          end
          case (am)
            itf_pkg::ALIGN_LEFT: begin
              ld      = 9'd0;
              trail_d = slack;
            end
            itf_pkg::ALIGN_RIGHT: begin
              ld      = slack;
              trail_d = 9'd0;
            end
            default: begin
              ld      = slack >> 1;
              trail_d = slack - (slack >> 1);
            end
          endcase
        end
        seg_d   = ld;
        rem_d   = {3'd0, blen} + {1'b0, slack};
        acc_d   = 64'd0;
        n_d     = 3'd0;
        state_d = itf_pkg::S_LEAD;
      end

      itf_pkg::S_LEAD: begin
        if (seg_q == 9'd0) begin
          seg_d   = {7'd0, hlen_q};
          state_d = itf_pkg::S_HEAD;
        end else begin
          emit  = 1'b1;
          ebyte = fill_q;
          seg_d = seg_q - 9'd1;
        end
      end

      itf_pkg::S_HEAD: begin
        if (seg_q == 9'd0) begin
          seg_d   = zeros_q;
          state_d = itf_pkg::S_ZERO;
        end else begin
          emit   = 1'b1;
          ebyte  = head_q[7:0];
          head_d = {8'd0, head_q[23:8]};
          seg_d  = seg_q - 9'd1;
        end
      end

      itf_pkg::S_ZERO: begin
        if (seg_q == 9'd0) begin
          seg_d   = {2'd0, nd_q};
          state_d = itf_pkg::S_DIGIT;
        end else begin
          emit  = 1'b1;
          ebyte = 8'h30;
          seg_d = seg_q - 9'd1;
        end
      end

      itf_pkg::S_DIGIT: begin
        if (seg_q == 9'd0) begin
          seg_d   = trail_q;
          state_d = itf_pkg::S_TRAIL;
        end else begin
          emit  = 1'b1;
          ebyte = itf_pkg::digit_char(top, upper_q);
          dig_d = dig_q << dw;
          seg_d = seg_q - 9'd1;
        end
      end

      itf_pkg::S_TRAIL: begin
        if (seg_q == 9'd0) begin
          state_d = itf_pkg::S_IDLE;
        end else begin
          emit  = 1'b1;
          ebyte = fill_q;
          seg_d = seg_q - 9'd1;
        end
      end

      default: state_d = itf_pkg::S_IDLE;
    endcase

    // chunk assembly: a full chunk or the final byte makes a transfer
    acc_new = acc_q;
    acc_new[8*n_q +: 8] = ebyte;
    if (emit) begin
      rem_d = rem_q - 10'd1;
      if (({1'b0, n_q} + 4'd1 == 4'(ChunkBytes)) || (rem_q == 10'd1)) begin
        ov_d  = 1'b1;
        oc_d  = acc_new;
        ob_d  = {1'b0, n_q} + 4'd1;
        ol_d  = (rem_q == 10'd1);
        oe_d  = 1'b0;
        acc_d = 64'd0;
        n_d   = 3'd0;
      end else begin
        acc_d = acc_new;
        n_d   = n_q + 3'd1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itf_pkg::S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    base_q    <= base_d;
    upper_q   <= upper_d;
    is_char_q <= is_char_d;
    src_q     <= src_d;
    dig_q     <= dig_d;
    nd_q      <= nd_d;
    cnt_q     <= cnt_d;
    head_q    <= head_d;
    hlen_q    <= hlen_d;
    seg_q     <= seg_d;
    zeros_q   <= zeros_d;
    trail_q   <= trail_d;
    rem_q     <= rem_d;
    acc_q     <= acc_d;
    n_q       <= n_d;
    oc_q      <= oc_d;
    ob_q      <= ob_d;
    ol_q      <= ol_d;
    oe_q      <= oe_d;
  end

  assign busy          = (state_q != itf_pkg::S_IDLE);
  assign valid_o       = ov_q;
  assign chunk_bytes_o = oc_q;
  assign byte_count_o  = ob_q;
  assign last_chunk_o  = ol_q;
  assign char_error_o  = oe_q;

endmodule
